// ===== src/pte_pkg.sv =====
// Shared types and constants of the pulse time envelope core.
// Used by the front, queue, back and top-level modules; no dependencies.
package pte_pkg;

    localparam int TIME_BITS     = 32;
    localparam int AMP_FRAC_BITS = 16;
    localparam int AMP_W         = AMP_FRAC_BITS + 1;
    localparam int DIST_W        = 37;
    localparam int DIV_STEPS     = 21;
    localparam int CFG_IDX_W     = 3;

    localparam logic [AMP_W-1:0]     AMP_ONE   = AMP_W'(1) << AMP_FRAC_BITS;
    localparam logic [TIME_BITS-1:0] TMASK     = '1;
    localparam logic [16:0]          PHASE_ONE = 17'h10000;

    // sin(pi/2 x) Taylor coefficients in Q30
    localparam logic [31:0] SC1 = 32'd1686629713;
    localparam logic [31:0] SC3 = 32'd693598668;
    localparam logic [31:0] SC5 = 32'd85569306;
    localparam logic [31:0] SC7 = 32'd5026995;
    localparam logic [31:0] SC9 = 32'd172272;

    localparam logic [31:0] INV_SQ2LN2_Q32 = 32'd3647809356;
    localparam logic [29:0] LN2_Q30        = 30'd744261118;
    localparam logic [30:0] ONE_Q30        = 31'h4000_0000;

    localparam logic [1:0] MODE_CONST = 2'd0;
    localparam logic [1:0] MODE_SINE  = 2'd1;
    localparam logic [1:0] MODE_GAUSS = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RISE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLATEAU = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF  = 3'd4;

    typedef enum logic [3:0] {
        CLS_ZERO  = 4'b0001,
        CLS_ONE   = 4'b0010,
        CLS_SINE  = 4'b0100,
        CLS_GAUSS = 4'b1000
    } cls_t;

    typedef struct packed {
        logic [1:0]           mode;
        logic [TIME_BITS-1:0] delay;
        logic [TIME_BITS-1:0] rise;
        logic [TIME_BITS-1:0] plateau;
        logic [3:0]           cutoff;
    } cfg_t;

    typedef struct packed {
        cls_t              cls;
        logic              fall;
        logic [DIST_W-1:0] offset;
    } item_t;

endpackage

// ===== src/pte_front.sv =====
// Front part: accepts time values, builds the window bounds and classifies
// each request into a segment kind and a distance. Depends on pte_pkg.
module pte_front
    import pte_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [TIME_BITS-1:0] in_time,
    output logic                 out_valid,
    input  logic                 out_ready,
    output item_t                out_item
);

    localparam int NST = 8;

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = (DIST_W+1)'(a) + (DIST_W+1)'(b);
        return (s > (DIST_W+1)'(TMASK)) ? TMASK : s[TIME_BITS-1:0];
    endfunction

    logic               vb_reg [NST];
    logic               adv;

    logic [TIME_BITS-1:0] t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg, t7_reg;
    logic [35:0]          cr2_reg;
    logic [63:0]          lo3_reg;
    logic [3:0]           ah3_reg;
    logic [DIST_W-1:0]    lt4_reg;
    logic [TIME_BITS-1:0] b1_5_reg, b1_6_reg, b1_7_reg, b2_6_reg, b2_7_reg, b3_7_reg;
    logic [DIST_W-1:0]    dl5_reg, dl6_reg, dl7_reg, len5_reg, len6_reg;
    item_t                item_reg;

    logic [DIST_W-1:0]    len_next;
    logic [DIST_W-1:0]    lt_next;
    item_t                item_next;

    assign adv       = !vb_reg[NST-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vb_reg[NST-1];
    assign out_item  = item_reg;

    assign lt_next  = DIST_W'(ah3_reg) * DIST_W'(INV_SQ2LN2_Q32)
                    + DIST_W'((65'(lo3_reg) + 65'h0_8000_0000) >> 32);
    assign len_next = (cfg.mode == MODE_GAUSS) ? lt4_reg : DIST_W'(cfg.rise);

    always_comb
    begin
        item_next.cls    = CLS_ZERO;
        item_next.fall   = 1'b0;
        item_next.offset = '0;
        unique case (cfg.mode) inside
            MODE_CONST:
            begin
                if (t7_reg > cfg.delay && t7_reg <= b1_7_reg)
                begin
                    item_next.cls = CLS_ONE;
                end
            end
            MODE_SINE, MODE_GAUSS:
            begin
                if (t7_reg <= cfg.delay)
                begin
                    item_next.cls = CLS_ZERO;
                end
                else if (t7_reg <= b1_7_reg)
                begin
                    item_next.cls    = (cfg.mode == MODE_SINE) ? CLS_SINE : CLS_GAUSS;
                    item_next.offset = (cfg.mode == MODE_SINE)
                                     ? DIST_W'(t7_reg - cfg.delay)
                                     : dl7_reg - DIST_W'(t7_reg);
                end
                else if (t7_reg <= b2_7_reg)
                begin
                    item_next.cls = CLS_ONE;
                end
                else if (t7_reg <= b3_7_reg)
                begin
                    item_next.cls    = (cfg.mode == MODE_SINE) ? CLS_SINE : CLS_GAUSS;
                    item_next.fall   = 1'b1;
                    item_next.offset = DIST_W'(t7_reg - b2_7_reg);
                end
            end
            default:
            begin
                item_next.cls = CLS_ZERO;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                vb_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vb_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
            begin
                vb_reg[i] <= vb_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg   <= in_time;
            t2_reg   <= t1_reg;
            cr2_reg  <= 36'(cfg.cutoff) * 36'(cfg.rise);
            t3_reg   <= t2_reg;
            lo3_reg  <= 64'(cr2_reg[31:0]) * 64'(INV_SQ2LN2_Q32);
            ah3_reg  <= cr2_reg[35:32];
            t4_reg   <= t3_reg;
            lt4_reg  <= lt_next;
            t5_reg   <= t4_reg;
            b1_5_reg <= sat_add(cfg.delay, len_next);
            dl5_reg  <= DIST_W'(cfg.delay) + lt4_reg;
            len5_reg <= len_next;
            t6_reg   <= t5_reg;
            b1_6_reg <= b1_5_reg;
            b2_6_reg <= sat_add(b1_5_reg, DIST_W'(cfg.plateau));
            dl6_reg  <= dl5_reg;
            len6_reg <= len5_reg;
            t7_reg   <= t6_reg;
            b1_7_reg <= b1_6_reg;
            b2_7_reg <= b2_6_reg;
            b3_7_reg <= sat_add(b2_6_reg, len6_reg);
            dl7_reg  <= dl6_reg;
            item_reg <= item_next;
        end
    end

endmodule

// ===== src/pte_queue.sv =====
// Short request queue between the front and the back part.
// Register storage, one read address; depends on pte_pkg.
module pte_queue
    import pte_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != (PTR_W+1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(DEPTH))
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not shrink on pop");

endmodule

// ===== src/pte_back.sv =====
// Back part: pipelined phase divider, sin^2 polynomial and 2^-x series.
// Produces one envelope value per request; depends on pte_pkg.
module pte_back
    import pte_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  item_t            in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [AMP_W-1:0] out_env
);

    localparam int POST = 30;
    localparam int PB   = DIV_STEPS + 1;
    localparam int NST  = PB + POST;
    localparam int NW   = DIST_W + 16;

    function automatic logic [32:0] recip_m(input logic [3:0] k);
        logic [32:0] m;
        case (k)
            4'd1:    m = 33'h1_0000_0000;
            4'd2:    m = 33'd2147483648;
            4'd3:    m = 33'd1431655765;
            4'd4:    m = 33'd1073741824;
            4'd5:    m = 33'd858993459;
            4'd6:    m = 33'd715827882;
            4'd7:    m = 33'd613566756;
            4'd8:    m = 33'd536870912;
            4'd9:    m = 33'd477218588;
            default: m = 33'h1_0000_0000;
        endcase
        return m;
    endfunction

    logic adv;
    logic vb_reg [NST];
    cls_t cls_reg [NST];

    // divider
    logic [31:0]          drem_reg [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] dq_reg   [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] dn_reg   [DIV_STEPS+1];
    logic                 fall_reg [DIV_STEPS+1];

    // sine path
    logic [16:0] sx_reg   [0:4];
    logic [16:0] sx2_reg  [0:3];
    logic [31:0] sacc_reg [1:4];
    logic [31:0] ss_reg;
    logic [63:0] ss2_reg;
    logic [AMP_W-1:0] sres_reg [7:28];

    // gaussian path
    logic [41:0] ge_reg;
    logic [29:0] gy_reg  [1:25];
    logic [9:0]  gei_reg [1:28];
    logic [30:0] gp_reg  [9];
    logic [30:0] gpc_reg [9];
    logic [30:0] gm_reg  [9];
    logic [30:0] gacc_reg [9];

    logic [AMP_W-1:0] env_reg;

    // stage 0 inputs
    logic [DIST_W-1:0] dist_c;
    logic              far;
    logic [NW-1:0]     num;
    cls_t              cls0;

    logic [DIV_STEPS-1:0] w;
    logic [16:0]          x_c;
    logic [AMP_W-1:0]     sres_c;
    logic [AMP_W-1:0]     gres_c;
    logic [AMP_W-1:0]     env_c;

    assign adv       = !vb_reg[NST-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vb_reg[NST-1];
    assign out_env   = env_reg;

    always_comb
    begin
        dist_c = in_item.offset;
        if (in_item.cls == CLS_SINE && in_item.offset > DIST_W'(cfg.rise))
        begin
            dist_c = DIST_W'(cfg.rise);
        end
        far  = (in_item.offset >= {1'b0, cfg.rise, 4'b0000});
        cls0 = (in_item.cls == CLS_GAUSS && far) ? CLS_ZERO : in_item.cls;
        num  = {dist_c, 16'h0000} + NW'(cfg.rise >> 1);
    end

    assign w = dq_reg[DIV_STEPS];

    always_comb
    begin
        x_c = fall_reg[DIV_STEPS] ? (PHASE_ONE - w[16:0]) : w[16:0];
        if (x_c > PHASE_ONE)
        begin
            x_c = PHASE_ONE;
        end
    end

    always_comb
    begin
        logic [64:0] r;
        r = (65'(ss2_reg) + (65'(1) << (59 - AMP_FRAC_BITS))) >> (60 - AMP_FRAC_BITS);
        sres_c = (r > 65'(AMP_ONE)) ? AMP_ONE : r[AMP_W-1:0];
    end

    always_comb
    begin
        logic [5:0]  sh;
        logic [47:0] r;
        sh = 6'(30 - AMP_FRAC_BITS) + gei_reg[28][5:0];
        r  = (48'(gacc_reg[8]) + (48'(1) << (sh - 6'd1))) >> sh;
        if (gei_reg[28] >= 10'd32)
        begin
            gres_c = '0;
        end
        else
        begin
            gres_c = (r > 48'(AMP_ONE)) ? AMP_ONE : r[AMP_W-1:0];
        end
    end

    always_comb
    begin
        unique case (cls_reg[NST-2])
            CLS_ONE:   env_c = AMP_ONE;
            CLS_SINE:  env_c = sres_reg[28];
            CLS_GAUSS: env_c = gres_c;
            default:   env_c = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                vb_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vb_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
            begin
                vb_reg[i] <= vb_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cls_reg[0] <= cls0;
            for (int i = 1; i < NST; i++)
            begin
                cls_reg[i] <= cls_reg[i-1];
            end

            // restoring divider, one quotient bit a stage
            drem_reg[0] <= num[NW-1 -: 32];
            dn_reg[0]   <= num[DIV_STEPS-1:0];
            dq_reg[0]   <= '0;
            fall_reg[0] <= in_item.fall;
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                logic [32:0] cand;
                logic        ge;
                cand = {drem_reg[i], dn_reg[i][DIV_STEPS-1]};
                ge   = (cand >= {1'b0, cfg.rise});
                drem_reg[i+1] <= ge ? 32'(cand - {1'b0, cfg.rise}) : cand[31:0];
                dq_reg[i+1]   <= {dq_reg[i][DIV_STEPS-2:0], ge};
                dn_reg[i+1]   <= dn_reg[i] << 1;
                fall_reg[i+1] <= fall_reg[i];
            end

            // sine squared
            sx_reg[0]   <= x_c;
            sx2_reg[0]  <= 17'((34'(x_c) * 34'(x_c)) >> 16);
            for (int i = 1; i < 5; i++)
            begin
                sx_reg[i] <= sx_reg[i-1];
            end
            for (int i = 1; i < 4; i++)
            begin
                sx2_reg[i] <= sx2_reg[i-1];
            end
            sacc_reg[1] <= SC7 - 32'((49'(SC9) * 49'(sx2_reg[0])) >> 16);
            sacc_reg[2] <= SC5 - 32'((49'(sacc_reg[1]) * 49'(sx2_reg[1])) >> 16);
            sacc_reg[3] <= SC3 - 32'((49'(sacc_reg[2]) * 49'(sx2_reg[2])) >> 16);
            sacc_reg[4] <= SC1 - 32'((49'(sacc_reg[3]) * 49'(sx2_reg[3])) >> 16);
            ss_reg      <= 32'((49'(sacc_reg[4]) * 49'(sx_reg[4])) >> 16);
            ss2_reg     <= 64'(ss_reg) * 64'(ss_reg);
            sres_reg[7] <= sres_c;
            for (int i = 8; i <= 28; i++)
            begin
                sres_reg[i] <= sres_reg[i-1];
            end

            // gaussian: e = w^2, 2^-frac(e) by a series, shift by int(e)
            ge_reg     <= 42'(w) * 42'(w);
            gei_reg[1] <= ge_reg[41:32];
            gy_reg[1]  <= 30'((64'(ge_reg[31:0]) * 64'(LN2_Q30)) >> 32);
            for (int i = 2; i <= 28; i++)
            begin
                gei_reg[i] <= gei_reg[i-1];
            end
            for (int i = 2; i <= 25; i++)
            begin
                gy_reg[i] <= gy_reg[i-1];
            end
            for (int j = 0; j < 9; j++)
            begin
                logic [30:0] acc_in;
                logic [3:0]  k;
                logic [34:0] diff;
                logic [30:0] q;
                k      = 4'(9 - j);
                acc_in = (j == 0) ? ONE_Q30 : gacc_reg[(j == 0) ? 0 : j - 1];
                gp_reg[j]  <= 31'((61'(acc_in) * 61'(gy_reg[1 + 3*j])) >> 30);
                gm_reg[j]  <= 31'((64'(gp_reg[j]) * 64'(recip_m(k))) >> 32);
                gpc_reg[j] <= gp_reg[j];
                diff = 35'(gpc_reg[j]) - 35'(gm_reg[j]) * 35'(k);
                q    = gm_reg[j] + 31'(diff >= 35'(k));
                gacc_reg[j] <= ONE_Q30 - q;
            end

            env_reg <= env_c;
        end
    end

endmodule

// ===== src/pulse_time_envelope_core.sv =====
// Top level of the pulse time envelope core: config registers, front part,
// request queue and back part. Depends on pte_pkg, pte_front, pte_queue, pte_back.

// Each request carries a time in ticks and returns one amplitude in unsigned
// Q1.16 (65536 is 1.0) for the programmed pulse: constant, sin^2 rise /
// plateau / cos^2 fall, or a cut gaussian; mode 3 gives 0. Requests are taken
// one per clock and results leave one per clock in request order while
// neither side stalls. A request passes the window classification, the
// 4-entry queue and the back pipeline, which holds the one-bit-a-stage phase
// divider by rise_ticks and the nine terms of the exponential series. Both
// sides stall independently; a full stall of the result side freezes the back
// pipeline and, once the queue fills, the front.
// Write config registers only while no request is in flight.
module pulse_time_envelope_core
    import pte_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // config write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [31:0] time_now
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata    // [16:0] envelope, [23:17] zero
);

    cfg_t  cfg_reg;
    logic  fq_valid, fq_ready, qb_valid, qb_ready;
    item_t fq_item, qb_item;
    logic [AMP_W-1:0] env;

    // Config writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode    <= MODE_CONST;
            cfg_reg.delay   <= '0;
            cfg_reg.rise    <= TIME_BITS'(1024);
            cfg_reg.plateau <= '0;
            cfg_reg.cutoff  <= 4'd3;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MODE:    cfg_reg.mode    <= cfg_data[1:0];
                REG_DELAY:   cfg_reg.delay   <= cfg_data[TIME_BITS-1:0];
                REG_RISE:    cfg_reg.rise    <= cfg_data[TIME_BITS-1:0];
                REG_PLATEAU: cfg_reg.plateau <= cfg_data[TIME_BITS-1:0];
                REG_CUTOFF:  cfg_reg.cutoff  <= cfg_data[3:0];
                default:     ;
            endcase
        end
    end

    // Classify each request into a segment kind and a distance.
    pte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_time   (s_tdata[TIME_BITS-1:0]),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_item  (fq_item)
    );

    // Decouple the two parts so each can stall on its own.
    pte_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // Evaluate the envelope shape for the classified request.
    pte_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (qb_valid),
        .in_ready  (qb_ready),
        .in_item   (qb_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_env   (env)
    );

    assign m_tdata = {7'b0000000, env};

endmodule
